FILE: hdl/ufv_pkg.sv
`default_nettype none

package ufv_pkg;

	typedef enum logic [1:0] {
		VERDICT_VALID     = 2'd0,
		VERDICT_CONTROL   = 2'd1,
		VERDICT_MALFORMED = 2'd2
	} verdict_t;

	typedef logic [1:0] owed_t;

	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_MARK    = 8'h80;
	localparam logic [7:0] ASCII_TOP    = 8'h80;
	localparam logic [7:0] LEAD2_LO     = 8'hC2;
	localparam logic [7:0] LEAD2_HI     = 8'hDF;
	localparam logic [3:0] LEAD3_NIBBLE = 4'hE;
	localparam logic [7:0] LEAD4_LO     = 8'hF0;
	localparam logic [7:0] LEAD4_HI     = 8'hF4;
	localparam logic [7:0] CTRL_BELOW   = 8'h20;
	localparam logic [7:0] CTRL_DEL     = 8'h7F;

	localparam owed_t OWED_NONE  = 2'd0;
	localparam owed_t OWED_ONE   = 2'd1;
	localparam owed_t OWED_TWO   = 2'd2;
	localparam owed_t OWED_THREE = 2'd3;

endpackage

`default_nettype wire

FILE: hdl/ufv_if.sv
`default_nettype none

interface ufv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ufv_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

`default_nettype wire

FILE: hdl/utf8_text_field_validator_core.sv
// UTF-8 text field validator.
//
// The text channel carries a message one byte per beat, with last_byte set on
// the final byte. The result channel carries one verdict beat per message:
// 0 valid, 1 a control character (below 0x20, or 0x7F) was present, 2 the
// UTF-8 structure was malformed. Control characters win over malformed
// structure, and a multi-byte sequence left open at the end is malformed.
//
// Each byte is captured in an input register and checked in the next cycle by
// a small decoder against the owed-continuation count and two sticky flags.
// The block takes one byte per clock unless stalled as described below. The
// verdict is written to an output register once the final byte is in the
// input register and the output register is free, and is held until taken.
//
// When the receiver stalls, bytes keep flowing in until a final byte reaches
// the input register while an untaken verdict is still held; the text channel
// then drops ready until the verdict beat completes.
//
// Reset clears both valid flags, the owed count and the sticky flags, so the
// first byte after reset starts a new message.
`default_nettype none

module utf8_text_field_validator_core (
	input  wire             clk,
	input  wire             arst_n,
	ufv_byte_if.sink        text,
	ufv_verdict_if.source   result
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	ufv_pkg::owed_t owed_q;
	logic           control_q;
	logic           malformed_q;

	logic             out_valid_q;
	ufv_pkg::verdict_t verdict_q;

	logic out_free;
	logic adv_s1;

	ufv_pkg::owed_t    owed_nx;
	logic              control_nx;
	logic              malformed_nx;
	ufv_pkg::verdict_t verdict_nx;

	assign out_free   = !out_valid_q || result.ready;
	assign adv_s1     = valid_s1 && (!last_s1 || out_free);
	assign text.ready = !valid_s1 || adv_s1;

	always_comb begin
		control_nx   = control_q || (data_s1 < ufv_pkg::CTRL_BELOW) ||
			(data_s1 == ufv_pkg::CTRL_DEL);
		malformed_nx = malformed_q;
		owed_nx      = owed_q;
		if (owed_q != ufv_pkg::OWED_NONE) begin
			// A bad continuation still uses up its slot.
			if ((data_s1 & ufv_pkg::CONT_MASK) != ufv_pkg::CONT_MARK) begin
				malformed_nx = 1'b1;
			end
			owed_nx = owed_q - ufv_pkg::OWED_ONE;
		end else if (data_s1 < ufv_pkg::ASCII_TOP) begin
			owed_nx = ufv_pkg::OWED_NONE;
		end else if (data_s1 >= ufv_pkg::LEAD2_LO && data_s1 <= ufv_pkg::LEAD2_HI) begin
			owed_nx = ufv_pkg::OWED_ONE;
		end else if (data_s1[7:4] == ufv_pkg::LEAD3_NIBBLE) begin
			owed_nx = ufv_pkg::OWED_TWO;
		end else if (data_s1 >= ufv_pkg::LEAD4_LO && data_s1 <= ufv_pkg::LEAD4_HI) begin
			owed_nx = ufv_pkg::OWED_THREE;
		end else begin
			malformed_nx = 1'b1;
		end

		if (control_nx) begin
			verdict_nx = ufv_pkg::VERDICT_CONTROL;
		end else if (malformed_nx || owed_nx != ufv_pkg::OWED_NONE) begin
			verdict_nx = ufv_pkg::VERDICT_MALFORMED;
		end else begin
			verdict_nx = ufv_pkg::VERDICT_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			data_s1 <= text.data_byte;
			last_s1 <= text.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q      <= ufv_pkg::OWED_NONE;
			control_q   <= 1'b0;
			malformed_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				owed_q      <= ufv_pkg::OWED_NONE;
				control_q   <= 1'b0;
				malformed_q <= 1'b0;
			end else begin
				owed_q      <= owed_nx;
				control_q   <= control_nx;
				malformed_q <= malformed_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && last_s1) begin
			verdict_q <= verdict_nx;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.verdict = verdict_q;

endmodule

`default_nettype wire

FILE: hdl/ufv_checker.sv
`default_nettype none

module ufv_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       in_last,
	input wire       out_valid,
	input wire       out_ready,
	input wire [1:0] out_verdict
);

	// A verdict beat must stay offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict beat dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_verdict))
		else $error("verdict changed while stalled");

	// A rising verdict valid must trace back to an accepted final byte.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("verdict without a final byte two cycles earlier");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_verdict != 2'd3)
		else $error("verdict code out of range");

endmodule

bind utf8_text_field_validator_core ufv_checker u_ufv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (text.valid),
	.in_ready   (text.ready),
	.in_last    (text.last_byte),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_verdict(result.verdict)
);

`default_nettype wire
